// ===== design/fqhs_pkg.sv =====
// Shared types and codes for the FIFO queue with in-place heap sort.
// No dependencies; used by every module of the block.
`default_nettype none

package fqhs_pkg;

    // Operation codes carried on the input tuser
    localparam logic [1:0] FUNC_ENQ  = 2'd0;
    localparam logic [1:0] FUNC_DEQ  = 2'd1;
    localparam logic [1:0] FUNC_SORT = 2'd2;

    // Result status codes carried on the output tuser
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Field widths of the stream payloads
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned OUT_W   = 40;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_TAKE,
        S_CHILD,
        S_CMP
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic acc_op;      // run enqueue, dequeue or a trivial operation
        logic sort_start;  // initialise the sort registers
        logic rd_load;     // read the entries of the next outer step
        logic take;        // capture the sift value
        logic child_rd;    // read both children of the current root
        logic put_v;       // write the sift value at the root
        logic put_big;     // move the larger child up and descend
        logic adv;         // advance to the next outer step
        logic finish;      // post the sort result
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;   // output register empty or being drained
        logic long_sort;  // offered item is a sort over two or more entries
        logic leaf;       // current root has no children inside the heap
        logic big_root;   // root value not smaller than either child
        logic last;       // final extraction step in progress
    } sts_t;

endpackage

`default_nettype wire

// ===== design/fifo_queue_with_heap_sort.sv =====
// Top level of the FIFO queue with in-place heap sort.
// Depends on fqhs_pkg, fqhs_ctrl and fqhs_dpath.
//
// A bounded FIFO of DEPTH signed 32-bit entries held in a ring store. Each
// input transfer carries one operation in s_tuser (enqueue, dequeue, sort)
// and the value to enqueue in s_tdata; each operation gives exactly one
// output transfer with the dequeued value (zero otherwise), a status in
// m_tuser (ok, dequeue on empty, enqueue dropped because full) and the
// entry count after the operation. Enqueue, dequeue and the unused code
// stream at one transfer per clock while the output register is free or
// being drained. A sort over n entries (n >= 2) runs a heap sort directly
// in the ring store, oldest position smallest: n/2 build steps and n-1
// extraction steps. Each step reads its root and captures it, then per heap
// level descended reads both children and compares, and places the value
// when it reaches a leaf or when a comparison ends the descent; s_tready
// stays low throughout. The sort speed is set by the store's single write
// port and its registered reads, which let one heap level move at a time.
// Sorting an empty or one-entry queue is handled like an enqueue or
// dequeue, without the sort steps. Entries never written read as anything;
// normal use never reads them.
`default_nettype none

module fifo_queue_with_heap_sort
#(
    parameter int DEPTH = 64
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [fqhs_pkg::VAL_W-1:0]  s_tdata,   // [31:0] value
    input  wire logic [1:0]                  s_tuser,   // [1:0] func
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [fqhs_pkg::OUT_W-1:0]       m_tdata,   // [31:0] data_out,
                                                        // [38:32] count_after
    output logic [1:0]                       m_tuser    // [1:0] status
);

    fqhs_pkg::cmd_t cmd;
    fqhs_pkg::sts_t sts;

    // Sequencer: one transfer at a time, sort steps driven one by one
    fqhs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Store, pointers, sift registers and the output register
    fqhs_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== design/fqhs_ctrl.sv =====
// Controller state machine for the queue: issues datapath commands.
// Depends on fqhs_pkg.
`default_nettype none

module fqhs_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire fqhs_pkg::sts_t  sts,
    output fqhs_pkg::cmd_t       cmd
);

    fqhs_pkg::state_t state_reg;
    fqhs_pkg::state_t state_next;

    logic accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fqhs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fqhs_pkg::S_IDLE:
            begin
                if (accept && sts.long_sort)
                begin
                    state_next = fqhs_pkg::S_LOAD;
                end
            end
            fqhs_pkg::S_LOAD:
            begin
                state_next = fqhs_pkg::S_TAKE;
            end
            fqhs_pkg::S_TAKE:
            begin
                state_next = fqhs_pkg::S_CHILD;
            end
            fqhs_pkg::S_CHILD:
            begin
                if (sts.leaf)
                begin
                    state_next = sts.last ? fqhs_pkg::S_IDLE : fqhs_pkg::S_LOAD;
                end
                else
                begin
                    state_next = fqhs_pkg::S_CMP;
                end
            end
            fqhs_pkg::S_CMP:
            begin
                if (sts.big_root)
                begin
                    state_next = sts.last ? fqhs_pkg::S_IDLE : fqhs_pkg::S_LOAD;
                end
                else
                begin
                    state_next = fqhs_pkg::S_CHILD;
                end
            end
            default:
            begin
                state_next = fqhs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            fqhs_pkg::S_IDLE:
            begin
                s_tready       = sts.out_free;
                cmd.sort_start = accept && sts.long_sort;
                cmd.acc_op     = accept && !sts.long_sort;
            end
            fqhs_pkg::S_LOAD:
            begin
                cmd.rd_load = 1'b1;
            end
            fqhs_pkg::S_TAKE:
            begin
                cmd.take = 1'b1;
            end
            fqhs_pkg::S_CHILD:
            begin
                if (sts.leaf)
                begin
                    cmd.put_v  = 1'b1;
                    cmd.finish = sts.last;
                    cmd.adv    = !sts.last;
                end
                else
                begin
                    cmd.child_rd = 1'b1;
                end
            end
            fqhs_pkg::S_CMP:
            begin
                if (sts.big_root)
                begin
                    cmd.put_v  = 1'b1;
                    cmd.finish = sts.last;
                    cmd.adv    = !sts.last;
                end
                else
                begin
                    cmd.put_big = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/fqhs_dpath.sv =====
// Datapath of the queue: ring store, head and count, heap sort registers
// and the output register. Depends on fqhs_pkg.
`default_nettype none

module fqhs_dpath
#(
    parameter int DEPTH = 64
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fqhs_pkg::cmd_t              cmd,
    output fqhs_pkg::sts_t                   sts,
    input  wire logic [1:0]                  s_tuser,
    input  wire logic [fqhs_pkg::VAL_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [fqhs_pkg::OUT_W-1:0]       m_tdata,
    output logic [1:0]                       m_tuser
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = AW + 2;
    localparam int XW = (CW > fqhs_pkg::CNT_W) ? CW : fqhs_pkg::CNT_W;

    logic signed [fqhs_pkg::VAL_W-1:0] mem [DEPTH];

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ext_reg, ext_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] n_reg, n_next;
    logic [AW-1:0] root_reg, root_next;
    logic signed [fqhs_pkg::VAL_W-1:0] v_reg, v_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_deq_reg, out_deq_next;
    logic [1:0]    out_stat_reg, out_stat_next;
    logic [CW-1:0] out_cnt_reg, out_cnt_next;

    logic signed [fqhs_pkg::VAL_W-1:0] rd0_reg, rd1_reg;
    logic [AW-1:0] ra0, ra1;
    logic          rd0_en, rd1_en;

    logic          we;
    logic [AW-1:0] wa;
    logic signed [fqhs_pkg::VAL_W-1:0] wd;

    logic [LW-1:0] left_i, right_i, big_i;
    logic          right_in, left_gt, right_gt;
    logic signed [fqhs_pkg::VAL_W-1:0] cand_val, big_val;
    logic          full, empty;
    logic [XW-1:0] cnt_x;

    function automatic logic [AW-1:0] ring(input logic [AW-1:0] hd,
                                           input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, hd} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // Heap children of the current root and the larger-child choice
    assign left_i   = {1'b0, root_reg, 1'b1};
    assign right_i  = left_i + LW'(1);
    assign right_in = (right_i < LW'(n_reg));
    assign left_gt  = (rd0_reg > v_reg);
    assign cand_val = left_gt ? rd0_reg : v_reg;
    assign right_gt = right_in && (rd1_reg > cand_val);
    assign big_val  = right_gt ? rd1_reg : rd0_reg;
    assign big_i    = right_gt ? right_i : left_i;

    assign sts.out_free  = !out_valid_reg || m_tready;
    assign sts.long_sort = (s_tuser == fqhs_pkg::FUNC_SORT) && (count_reg > CW'(1));
    assign sts.leaf      = (left_i >= LW'(n_reg));
    assign sts.big_root  = !left_gt && !right_gt;
    assign sts.last      = ext_reg && (idx_reg == AW'(1));

    // Read addresses
    always_comb
    begin
        ra0 = head_reg;
        ra1 = head_reg;
        if (cmd.rd_load)
        begin
            ra0 = ext_reg ? head_reg : ring(head_reg, idx_reg);
            ra1 = ring(head_reg, idx_reg);
        end
        else if (cmd.child_rd)
        begin
            ra0 = ring(head_reg, left_i[AW-1:0]);
            ra1 = right_in ? ring(head_reg, right_i[AW-1:0])
                           : ring(head_reg, left_i[AW-1:0]);
        end
    end

    assign rd0_en = cmd.acc_op || cmd.rd_load || cmd.child_rd;
    assign rd1_en = cmd.rd_load || cmd.child_rd;

    // Single write port
    always_comb
    begin
        we = 1'b0;
        wa = root_reg;
        wd = v_reg;
        priority if (cmd.acc_op && (s_tuser == fqhs_pkg::FUNC_ENQ) && !full)
        begin
            we = 1'b1;
            wa = ring(head_reg, count_reg[AW-1:0]);
            wd = s_tdata;
        end
        else if (cmd.take && ext_reg)
        begin
            we = 1'b1;
            wa = ring(head_reg, idx_reg);
            wd = rd0_reg;
        end
        else if (cmd.put_v)
        begin
            we = 1'b1;
            wa = ring(head_reg, root_reg);
            wd = v_reg;
        end
        else if (cmd.put_big)
        begin
            we = 1'b1;
            wa = ring(head_reg, root_reg);
            wd = big_val;
        end
        else
        begin
            we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd0_en)
        begin
            rd0_reg <= mem[ra0];
        end
        if (rd1_en)
        begin
            rd1_reg <= mem[ra1];
        end
    end

    // Next values of queue, sort and output registers
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        ext_next       = ext_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        root_next      = root_reg;
        v_next         = v_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_deq_next   = out_deq_reg;
        out_stat_next  = out_stat_reg;
        out_cnt_next   = out_cnt_reg;

        if (cmd.acc_op)
        begin
            out_valid_next = 1'b1;
            out_deq_next   = 1'b0;
            out_stat_next  = fqhs_pkg::STAT_OK;
            out_cnt_next   = count_reg;
            if (s_tuser == fqhs_pkg::FUNC_ENQ)
            begin
                if (full)
                begin
                    out_stat_next = fqhs_pkg::STAT_FULL;
                end
                else
                begin
                    count_next   = count_reg + CW'(1);
                    out_cnt_next = count_reg + CW'(1);
                end
            end
            else if (s_tuser == fqhs_pkg::FUNC_DEQ)
            begin
                if (empty)
                begin
                    out_stat_next = fqhs_pkg::STAT_EMPTY;
                end
                else
                begin
                    out_deq_next = 1'b1;
                    head_next    = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
                    count_next   = count_reg - CW'(1);
                    out_cnt_next = count_reg - CW'(1);
                end
            end
        end

        if (cmd.sort_start)
        begin
            ext_next = 1'b0;
            n_next   = count_reg;
            idx_next = AW'((count_reg >> 1) - CW'(1));
        end

        if (cmd.take)
        begin
            v_next    = ext_reg ? rd1_reg : rd0_reg;
            root_next = ext_reg ? '0 : idx_reg;
            n_next    = ext_reg ? CW'(idx_reg) : n_reg;
        end

        if (cmd.put_big)
        begin
            root_next = big_i[AW-1:0];
        end

        if (cmd.adv)
        begin
            if (!ext_reg && (idx_reg == '0))
            begin
                ext_next = 1'b1;
                idx_next = AW'(count_reg - CW'(1));
            end
            else
            begin
                idx_next = idx_reg - AW'(1);
            end
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            out_deq_next   = 1'b0;
            out_stat_next  = fqhs_pkg::STAT_OK;
            out_cnt_next   = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            ext_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            ext_reg       <= ext_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        root_reg     <= root_next;
        v_reg        <= v_next;
        out_deq_reg  <= out_deq_next;
        out_stat_reg <= out_stat_next;
        out_cnt_reg  <= out_cnt_next;
    end

    // Hold the dequeued value in the read register until the transfer
    assign cnt_x    = XW'(out_cnt_reg);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tdata  = {1'b0, cnt_x[fqhs_pkg::CNT_W-1:0],
                       (out_deq_reg ? rd0_reg : '0)};

endmodule

`default_nettype wire

// ===== design/fqhs_checker.sv =====
// Port-level checker for the queue, bound to the top level.
// Depends on fqhs_pkg and fifo_queue_with_heap_sort.
`default_nettype none

module fqhs_checker
#(
    parameter int DEPTH = 64
)
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [fqhs_pkg::OUT_W-1:0]  m_tdata,
    input wire logic [1:0]                  m_tuser
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Input taken only when the output register can take the result
    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid || m_tready)
        else $error("input ready while output register blocked");

    // Dequeue on empty carries zero data and zero count
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == fqhs_pkg::STAT_EMPTY) |-> (m_tdata == '0))
        else $error("empty status with non-zero payload");

    // A dropped enqueue reports a full queue
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == fqhs_pkg::STAT_FULL)
            |-> (m_tdata[38:32] == 7'(DEPTH)) && (m_tdata[31:0] == '0))
        else $error("full status with wrong count or data");

endmodule

bind fifo_queue_with_heap_sort fqhs_checker #(.DEPTH(DEPTH)) u_fqhs_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for fifo_queue_with_heap_sort: streams enqueue, dequeue, sort and
// unused-code transfers, predicts each result in a local queue model and checks every field.
// Depends on fqhs_pkg and the RTL of the block only.

module testbench;

    localparam int         DEPTH        = 64;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;     // operation code the block must ignore
    localparam int         CYCLE_LIMIT  = 3_000_000;
    localparam int         DRAIN_CYCLES = 64;

    // Receiver behaviour for m_tready
    typedef enum int
    {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_LONG
    } rx_mode_t;

    // One predicted output transfer
    typedef struct
    {
        logic [31:0] data_out;
        logic [1:0]  status;
        logic [6:0]  count_after;
    } outcome_t;

    // DUT connections; every input starts at a known value
    logic                       clk      = 1'b0;
    logic                       rst_n    = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [31:0]                s_tdata  = '0;                  // [31:0] value
    logic [1:0]                 s_tuser  = fqhs_pkg::FUNC_ENQ;  // [1:0] func
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [fqhs_pkg::OUT_W-1:0] m_tdata;        // [31:0] data_out, [38:32] count_after
    logic [1:0]                 m_tuser;        // [1:0] status

    // Queue model: ring store addressed from the oldest entry
    int          ring_store [DEPTH];
    int          sort_buf   [DEPTH];
    int unsigned head_pos = 0;
    int unsigned held     = 0;

    // Results still owed by the block, oldest first
    outcome_t queued_outcomes [$];

    // Stimulus pacing
    bit       tx_gaps    = 1'b0;
    int       burst_left = 0;
    rx_mode_t rx_mode    = RX_ALWAYS;
    int       rx_phase   = 0;
    int       stall_left = 0;

    // Bookkeeping
    int error_count   = 0;
    int results_seen  = 0;
    int cycle_count   = 0;
    int n_enq         = 0;
    int n_dropped     = 0;
    int n_deq         = 0;
    int n_deq_empty   = 0;
    int n_sort        = 0;
    int n_unused      = 0;
    int largest_sort  = 0;

    fifo_queue_with_heap_sort #(
        .DEPTH (DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Queue model
    // ------------------------------------------------------------------

    // Push the root down the max-heap held in sort_buf[0 .. n-1]
    function automatic void sift_down(int n, int root);
        int big;
        int left;
        int right;
        int t;
        bit settled = 1'b0;
        while (!settled)
        begin
            big   = root;
            left  = 2 * root + 1;
            right = 2 * root + 2;
            if (left < n && sort_buf[left] > sort_buf[big])
                big = left;
            if (right < n && sort_buf[right] > sort_buf[big])
                big = right;
            if (big == root)
                settled = 1'b1;
            else
            begin
                t              = sort_buf[root];
                sort_buf[root] = sort_buf[big];
                sort_buf[big]  = t;
                root           = big;
            end
        end
    endfunction

    // Sort the held entries in place, smallest at the oldest position
    function automatic void heap_sort_contents();
        int n;
        int t;
        n = held;
        if (n <= 1)
            return;
        if (n > largest_sort)
            largest_sort = n;
        for (int i = 0; i < n; i++)
            sort_buf[i] = ring_store[(head_pos + i) % DEPTH];
        for (int i = n / 2; i > 0; i--)
            sift_down(n, i - 1);
        for (int i = n - 1; i > 0; i--)
        begin
            t           = sort_buf[0];
            sort_buf[0] = sort_buf[i];
            sort_buf[i] = t;
            sift_down(i, 0);
        end
        for (int i = 0; i < n; i++)
            ring_store[(head_pos + i) % DEPTH] = sort_buf[i];
    endfunction

    // Advance the model by one accepted transfer and return the result it owes
    function automatic outcome_t apply_queue_op(logic [1:0] op, logic [31:0] value);
        outcome_t res;
        res.data_out = '0;
        res.status   = fqhs_pkg::STAT_OK;
        case (op)
            fqhs_pkg::FUNC_ENQ:
            begin
                n_enq++;
                if (held >= DEPTH)
                begin
                    res.status = fqhs_pkg::STAT_FULL;
                    n_dropped++;
                end
                else
                begin
                    ring_store[(head_pos + held) % DEPTH] = value;
                    held++;
                end
            end
            fqhs_pkg::FUNC_DEQ:
            begin
                n_deq++;
                if (held == 0)
                begin
                    res.status = fqhs_pkg::STAT_EMPTY;
                    n_deq_empty++;
                end
                else
                begin
                    res.data_out = ring_store[head_pos];
                    head_pos     = (head_pos + 1) % DEPTH;
                    held--;
                end
            end
            fqhs_pkg::FUNC_SORT:
            begin
                n_sort++;
                heap_sort_contents();
            end
            default:
                n_unused++;
        endcase
        res.count_after = held[6:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one item, hold it until the transfer, then predict its result.
    // With gaps enabled, between bursts drop tvalid for a random gap and scramble the data bus.
    task automatic send_op(input logic [1:0] op, input logic [31:0] value);
        outcome_t res;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        res = apply_queue_op(op, value);
        queued_outcomes.push_back(res);
        if (tx_gaps)
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= $urandom;
                s_tuser  <= 2'($urandom);
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(0, 12);
            end
            else
                burst_left--;
        end
    endtask

    // Mostly full-range values, with extremes and a narrow band that forces duplicates
    function automatic logic [31:0] rand_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            1: v = 32'($signed($urandom_range(0, 16)) - 8);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Lower tvalid, wait for every owed result, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (queued_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        rx_phase <= (rx_phase + 1) % 7;
        case (rx_mode)
            RX_ALWAYS:
                m_tready <= 1'b1;
            RX_RANDOM:
                m_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC:
                m_tready <= (rx_phase < 4);
            default:
            begin
                // occasional long stalls between runs of full readiness
                if (stall_left > 0)
                begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    stall_left = $urandom_range(5, 30);
                    m_tready <= 1'b0;
                end
                else
                    m_tready <= 1'b1;
            end
        endcase
    end

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Compare each output transfer with the oldest owed result
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (queued_outcomes.size() == 0)
                report_mismatch("result with nothing owed", m_tdata, '0);
            else
            begin
                want = queued_outcomes.pop_front();
                if (m_tdata[31:0] !== want.data_out)
                    report_mismatch("data_out", 40'(m_tdata[31:0]), 40'(want.data_out));
                if (m_tuser !== want.status)
                    report_mismatch("status", 40'(m_tuser), 40'(want.status));
                if (m_tdata[38:32] !== want.count_after)
                    report_mismatch("count_after", 40'(m_tdata[38:32]),
                                    40'(want.count_after));
            end
        end
    end

    // Hard stop if the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles, %0d results still owed", cycle_count,
                     queued_outcomes.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty and single-entry corners, the ignored code, value extremes and a small sort
    task automatic test_directed();
        tx_gaps = 1'b0;
        rx_mode = RX_ALWAYS;
        send_op(fqhs_pkg::FUNC_DEQ, 32'h1234_5678);     // dequeue on empty
        send_op(fqhs_pkg::FUNC_SORT, 32'h0000_0000);    // sort with nothing held
        send_op(FUNC_UNUSED, 32'hFFFF_FFFF);            // ignored code
        send_op(fqhs_pkg::FUNC_ENQ, 32'h7FFF_FFFF);
        send_op(fqhs_pkg::FUNC_SORT, 32'hFFFF_FFFF);    // sort with one entry
        send_op(fqhs_pkg::FUNC_ENQ, 32'h8000_0000);
        send_op(fqhs_pkg::FUNC_ENQ, 32'h0000_0000);
        send_op(fqhs_pkg::FUNC_ENQ, 32'hFFFF_FFFF);
        send_op(fqhs_pkg::FUNC_ENQ, 32'h0000_0001);
        send_op(fqhs_pkg::FUNC_ENQ, 32'h7FFF_FFFF);     // duplicate of the largest value
        send_op(FUNC_UNUSED, 32'h8000_0000);
        send_op(fqhs_pkg::FUNC_SORT, 32'h5555_AAAA);
        repeat (6) send_op(fqhs_pkg::FUNC_DEQ, 32'hAAAA_5555);
        send_op(fqhs_pkg::FUNC_DEQ, 32'h0000_0000);     // empty again
        wait_idle();
    endtask

    // Mixed traffic with pacing and receiver behaviour reshuffled every few dozen items
    task automatic test_random_mix(input int n_items);
        int r;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
            begin
                tx_gaps = 1'($urandom_range(0, 1));
                rx_mode = rx_mode_t'($urandom_range(0, 3));
            end
            r = $urandom_range(0, 99);
            if (r < 45)
                send_op(fqhs_pkg::FUNC_ENQ, rand_value());
            else if (r < 80)
                send_op(fqhs_pkg::FUNC_DEQ, $urandom);
            else if (r < 94)
                send_op(fqhs_pkg::FUNC_SORT, $urandom);
            else
                send_op(FUNC_UNUSED, $urandom);
        end
    endtask

    // Fill to capacity across the ring wrap, overflow, sort a full store, drain past empty
    task automatic test_fill_drain(input int rounds);
        int r;
        for (int k = 0; k < rounds; k++)
        begin
            tx_gaps = (k != 0);
            rx_mode = (k == 0) ? RX_ALWAYS : ((k % 2 != 0) ? RX_LONG : RX_PERIODIC);
            while (held < DEPTH)
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    send_op(fqhs_pkg::FUNC_SORT, $urandom);
                else if (r < 10)
                    send_op(FUNC_UNUSED, $urandom);
                else if (r < 13)
                    send_op(fqhs_pkg::FUNC_DEQ, $urandom);
                else
                    send_op(fqhs_pkg::FUNC_ENQ, rand_value());
            end
            repeat (3) send_op(fqhs_pkg::FUNC_ENQ, rand_value());   // dropped while full
            send_op(fqhs_pkg::FUNC_SORT, $urandom);
            while (held > 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    send_op(fqhs_pkg::FUNC_SORT, $urandom);
                else if (r < 10)
                    send_op(fqhs_pkg::FUNC_ENQ, rand_value());
                else
                    send_op(fqhs_pkg::FUNC_DEQ, $urandom);
            end
            repeat (2) send_op(fqhs_pkg::FUNC_DEQ, $urandom);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mix(220);
        test_fill_drain(2);
        wait_idle();

        $display("Covered %0d enqueues (%0d dropped full), %0d dequeues (%0d on empty),",
                 n_enq, n_dropped, n_deq, n_deq_empty);
        $display("%0d sorts (largest %0d entries), %0d ignored codes; %0d results in %0d cycles",
                 n_sort, largest_sort, n_unused, results_seen, cycle_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
